### sv/cmap4_pkg.sv
// shared types, codes and widths for the format-4 glyph lookup
package cmap4_pkg;

    localparam int WORD_W  = 16;
    localparam int SEG_W   = 10;
    localparam int SUBC_W  = 9;
    localparam int MODE_W  = 2;
    localparam int WADDR_W = 12;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 10;
    localparam int STAT_W  = 2;
    // wide enough for any map address the lookup can form, and for the default depths
    localparam int ADDR_W  = 18;

    localparam int DEF_MAP_DEPTH   = 4096;
    localparam int DEF_SUBST_DEPTH = 256;

    localparam logic [MODE_W-1:0] MODE_MAP_WR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB_WR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] ST_MAPPED   = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNMAPPED = 2'd1;
    localparam logic [STAT_W-1:0] ST_OOB      = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_SEG_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SUB_COUNT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_VERT_EN   = 2'd2;

    typedef enum logic [2:0] {
        AS_SEG   = 3'd0,
        AS_START = 3'd1,
        AS_DELTA = 3'd2,
        AS_OFFS  = 3'd3,
        AS_GLYPH = 3'd4
    } t_asel;

    typedef enum logic [1:0] {
        GL_DELTA = 2'd0,
        GL_ARRAY = 2'd1,
        GL_SUBST = 2'd2
    } t_gsel;

    typedef struct packed {
        logic              accept;
        logic              map_rd;
        t_asel             asel;
        logic              idx_inc;
        logic              cap_start;
        logic              cap_delta;
        logic              cap_offs;
        logic              gaddr_ld;
        logic              glyph_ld;
        t_gsel             gsel;
        logic              sub_rd;
        logic              k_clr;
        logic              k_inc;
        logic              fin;
        logic [STAT_W-1:0] fin_status;
        logic              push;
    } t_cmd;

    typedef struct packed {
        logic seg_end;
        logic seg_oob;
        logic seg_hit;
        logic fld_oob;
        logic below_start;
        logic offs_zero;
        logic g_oob;
        logic g_zero;
        logic vert;
        logic sub_end;
        logic sub_less;
        logic sub_eq;
        logic out_free;
    } t_stat;

endpackage

### sv/cmap4_ctrl.sv
// lookup sequencer: walks segments, fields, glyph array and substitution list
module cmap4_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [cmap4_pkg::MODE_W-1:0]   i_mode,
    input  cmap4_pkg::t_stat               i_stat,
    output logic                           o_in_ready,
    output cmap4_pkg::t_cmd                o_cmd
);
    import cmap4_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_SEG_RD  = 14'b00000000000010,
        S_SEG_CHK = 14'b00000000000100,
        S_FLD_RD0 = 14'b00000000001000,
        S_FLD_RD1 = 14'b00000000010000,
        S_FLD_RD2 = 14'b00000000100000,
        S_FLD_CAP = 14'b00000001000000,
        S_EVAL    = 14'b00000010000000,
        S_GA_CHK  = 14'b00000100000000,
        S_GA_CAP  = 14'b00001000000000,
        S_GCHK    = 14'b00010000000000,
        S_SUB_RD  = 14'b00100000000000,
        S_SUB_CHK = 14'b01000000000000,
        S_RESP    = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.asel = AS_SEG;
        o_cmd.gsel = GL_DELTA;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_mode == MODE_LOOKUP) begin
                        n_state = S_SEG_RD;
                    end
                end
            end
            S_SEG_RD: begin
                if (i_stat.seg_end) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_UNMAPPED;
                    n_state          = S_RESP;
                end else if (i_stat.seg_oob) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_OOB;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.map_rd = 1'b1;
                    o_cmd.asel   = AS_SEG;
                    n_state      = S_SEG_CHK;
                end
            end
            S_SEG_CHK: begin
                if (i_stat.seg_hit) begin
                    n_state = S_FLD_RD0;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SEG_RD;
                end
            end
            S_FLD_RD0: begin
                // offset word is the highest of the three, so it covers all
                if (i_stat.fld_oob) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_OOB;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.map_rd = 1'b1;
                    o_cmd.asel   = AS_START;
                    n_state      = S_FLD_RD1;
                end
            end
            S_FLD_RD1: begin
                o_cmd.cap_start = 1'b1;
                o_cmd.map_rd    = 1'b1;
                o_cmd.asel      = AS_DELTA;
                n_state         = S_FLD_RD2;
            end
            S_FLD_RD2: begin
                o_cmd.cap_delta = 1'b1;
                o_cmd.map_rd    = 1'b1;
                o_cmd.asel      = AS_OFFS;
                n_state         = S_FLD_CAP;
            end
            S_FLD_CAP: begin
                o_cmd.cap_offs = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.below_start) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_UNMAPPED;
                    n_state          = S_RESP;
                end else if (i_stat.offs_zero) begin
                    o_cmd.glyph_ld = 1'b1;
                    o_cmd.gsel     = GL_DELTA;
                    n_state        = S_GCHK;
                end else begin
                    o_cmd.gaddr_ld = 1'b1;
                    n_state        = S_GA_CHK;
                end
            end
            S_GA_CHK: begin
                if (i_stat.g_oob) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_OOB;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.map_rd = 1'b1;
                    o_cmd.asel   = AS_GLYPH;
                    n_state      = S_GA_CAP;
                end
            end
            S_GA_CAP: begin
                o_cmd.glyph_ld = 1'b1;
                o_cmd.gsel     = GL_ARRAY;
                n_state        = S_GCHK;
            end
            S_GCHK: begin
                if (i_stat.g_zero) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_UNMAPPED;
                    n_state          = S_RESP;
                end else if (!i_stat.vert) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_MAPPED;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_SUB_RD;
                end
            end
            S_SUB_RD: begin
                if (i_stat.sub_end) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_MAPPED;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.sub_rd = 1'b1;
                    n_state      = S_SUB_CHK;
                end
            end
            S_SUB_CHK: begin
                if (i_stat.sub_less) begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_SUB_RD;
                end else begin
                    if (i_stat.sub_eq) begin
                        o_cmd.glyph_ld = 1'b1;
                        o_cmd.gsel     = GL_SUBST;
                    end
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_MAPPED;
                    n_state          = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/cmap4_dp.sv
// datapath: map and substitution memories, config registers, address math, result register
module cmap4_dp #(
    parameter int MAP_DEPTH   = cmap4_pkg::DEF_MAP_DEPTH,
    parameter int SUBST_DEPTH = cmap4_pkg::DEF_SUBST_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cmap4_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [cmap4_pkg::CDATA_W-1:0]   i_cfg_data,
    input  logic [cmap4_pkg::MODE_W-1:0]    i_mode,
    input  logic [cmap4_pkg::WADDR_W-1:0]   i_word_address,
    input  logic [cmap4_pkg::WORD_W-1:0]    i_word_value,
    input  logic [cmap4_pkg::WORD_W-1:0]    i_replacement_glyph,
    input  logic [cmap4_pkg::WORD_W-1:0]    i_code_point,
    input  cmap4_pkg::t_cmd                 i_cmd,
    output cmap4_pkg::t_stat                o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cmap4_pkg::WORD_W-1:0]    o_glyph_index,
    output logic [cmap4_pkg::STAT_W-1:0]    o_status
);
    import cmap4_pkg::*;

    localparam int MAW = $clog2(MAP_DEPTH);
    localparam int SW  = (SUBST_DEPTH > 1) ? $clog2(SUBST_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] MAP_LIM = ADDR_W'(MAP_DEPTH);
    localparam logic [ADDR_W-1:0] SUB_LIM = ADDR_W'(SUBST_DEPTH);

    logic [WORD_W-1:0]   r_map_mem [MAP_DEPTH];
    logic [2*WORD_W-1:0] r_sub_mem [SUBST_DEPTH];

    logic [SEG_W-1:0]    r_seg_count;
    logic [SUBC_W-1:0]   r_sub_count;
    logic                r_vert_en;

    logic [WORD_W-1:0]   r_cp;
    logic [SEG_W-1:0]    r_idx;
    logic [WORD_W-1:0]   r_start;
    logic [WORD_W-1:0]   r_delta;
    logic [WORD_W-1:0]   r_offs;
    logic [ADDR_W-1:0]   r_gaddr;
    logic [WORD_W-1:0]   r_glyph;
    logic [SUBC_W-1:0]   r_k;
    logic [STAT_W-1:0]   r_pend_status;
    logic [WORD_W-1:0]   r_map_q;
    logic [2*WORD_W-1:0] r_sub_q;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_glyph;
    logic [STAT_W-1:0]   r_out_status;

    logic [ADDR_W-1:0]   w_seg_x;
    logic [ADDR_W-1:0]   w_idx_x;
    logic [ADDR_W-1:0]   w_start_a;
    logic [ADDR_W-1:0]   w_delta_a;
    logic [ADDR_W-1:0]   w_offs_a;
    logic [ADDR_W-1:0]   w_rd_a;
    logic [ADDR_W-1:0]   w_wr_a;
    logic [ADDR_W-1:0]   w_sub_n;
    logic [ADDR_W-1:0]   w_k_x;
    logic                w_map_we;
    logic                w_sub_we;
    logic [WORD_W-1:0]   w_sub_from;
    logic [WORD_W-1:0]   w_sub_to;
    logic [WORD_W-1:0]   n_glyph;

    // address arithmetic
    assign w_seg_x   = ADDR_W'(r_seg_count);
    assign w_idx_x   = ADDR_W'(r_idx);
    assign w_start_a = w_seg_x + w_idx_x + ADDR_W'(1);
    assign w_delta_a = w_start_a + w_seg_x;
    assign w_offs_a  = w_delta_a + w_seg_x;
    assign w_wr_a    = ADDR_W'(i_word_address);
    assign w_sub_n   = (ADDR_W'(r_sub_count) < SUB_LIM) ? ADDR_W'(r_sub_count) : SUB_LIM;
    assign w_k_x     = ADDR_W'(r_k);
    assign w_sub_from = r_sub_q[2*WORD_W-1:WORD_W];
    assign w_sub_to   = r_sub_q[WORD_W-1:0];

    assign w_map_we = i_cmd.accept && (i_mode == MODE_MAP_WR) && (w_wr_a < MAP_LIM);
    assign w_sub_we = i_cmd.accept && (i_mode == MODE_SUB_WR) && (w_wr_a < SUB_LIM);

    always_comb begin
        case (i_cmd.asel)
            AS_SEG:   w_rd_a = w_idx_x;
            AS_START: w_rd_a = w_start_a;
            AS_DELTA: w_rd_a = w_delta_a;
            AS_OFFS:  w_rd_a = w_offs_a;
            AS_GLYPH: w_rd_a = r_gaddr;
            default:  w_rd_a = w_idx_x;
        endcase
    end

    always_comb begin
        case (i_cmd.gsel)
            GL_DELTA: n_glyph = r_cp + r_delta;
            GL_ARRAY: n_glyph = (r_map_q != '0) ? (r_map_q + r_delta) : '0;
            GL_SUBST: n_glyph = w_sub_to;
            default:  n_glyph = r_glyph;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map_mem[w_wr_a[MAW-1:0]] <= i_word_value;
        end
        if (i_cmd.map_rd) begin
            r_map_q <= r_map_mem[w_rd_a[MAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sub_we) begin
            r_sub_mem[w_wr_a[SW-1:0]] <= {i_word_value, i_replacement_glyph};
        end
        if (i_cmd.sub_rd) begin
            r_sub_q <= r_sub_mem[w_k_x[SW-1:0]];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= SEG_W'(1);
            r_sub_count <= '0;
            r_vert_en   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEG_COUNT: r_seg_count <= i_cfg_data[SEG_W-1:0];
                CFG_SUB_COUNT: r_sub_count <= i_cfg_data[SUBC_W-1:0];
                CFG_VERT_EN:   r_vert_en   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // lookup working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cp  <= i_code_point;
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + SEG_W'(1);
        end
        if (i_cmd.cap_start) begin
            r_start <= r_map_q;
        end
        if (i_cmd.cap_delta) begin
            r_delta <= r_map_q;
        end
        if (i_cmd.cap_offs) begin
            r_offs <= r_map_q;
        end
        if (i_cmd.gaddr_ld) begin
            r_gaddr <= w_offs_a + ADDR_W'(r_offs[WORD_W-1:1]) + ADDR_W'(r_cp - r_start);
        end
        if (i_cmd.glyph_ld) begin
            r_glyph <= n_glyph;
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + SUBC_W'(1);
        end
        if (i_cmd.fin) begin
            r_pend_status <= i_cmd.fin_status;
        end
        if (i_cmd.push) begin
            r_out_glyph  <= (r_pend_status == ST_MAPPED) ? r_glyph : '0;
            r_out_status <= r_pend_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.seg_end     = r_idx >= r_seg_count;
        o_stat.seg_oob     = w_idx_x >= MAP_LIM;
        o_stat.seg_hit     = r_cp <= r_map_q;
        o_stat.fld_oob     = w_offs_a >= MAP_LIM;
        o_stat.below_start = r_cp < r_start;
        o_stat.offs_zero   = r_offs == '0;
        o_stat.g_oob       = r_gaddr >= MAP_LIM;
        o_stat.g_zero      = r_glyph == '0;
        o_stat.vert        = r_vert_en;
        o_stat.sub_end     = w_k_x >= w_sub_n;
        o_stat.sub_less    = w_sub_from < r_glyph;
        o_stat.sub_eq      = w_sub_from == r_glyph;
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_glyph_index = r_out_glyph;
    assign o_status      = r_out_status;

endmodule

### sv/cmap4_glyph_lookup.sv
// top level of the format-4 character map lookup with vertical substitution
//
//  port group   direction  handshake                    payload
//  cfg          in         i_cfg_we                     i_cfg_index, i_cfg_data
//  request      in         i_in_valid / o_in_ready      i_mode, i_word_address, i_word_value,
//                                                       i_replacement_glyph, i_code_point
//  result       out        o_out_valid / i_out_ready    o_glyph_index, o_status
//
// map and substitution writes and no-op requests complete as they are accepted.
// a lookup is accepted, then scans segments, reads the segment fields and the glyph array word,
// scans substitution entries when vertical substitution is on
// and delivers the result; every step goes through the single read port of a memory.
// the result register lets the next request in while a result waits to be taken.
// synchronous active-low reset clears control and configuration; memories are not cleared.
module cmap4_glyph_lookup #(
    parameter int MAP_DEPTH   = cmap4_pkg::DEF_MAP_DEPTH,
    parameter int SUBST_DEPTH = cmap4_pkg::DEF_SUBST_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cmap4_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [cmap4_pkg::CDATA_W-1:0]   i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [cmap4_pkg::MODE_W-1:0]    i_mode,
    input  logic [cmap4_pkg::WADDR_W-1:0]   i_word_address,
    input  logic [cmap4_pkg::WORD_W-1:0]    i_word_value,
    input  logic [cmap4_pkg::WORD_W-1:0]    i_replacement_glyph,
    input  logic [cmap4_pkg::WORD_W-1:0]    i_code_point,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cmap4_pkg::WORD_W-1:0]    o_glyph_index,
    output logic [cmap4_pkg::STAT_W-1:0]    o_status
);
    import cmap4_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    cmap4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    cmap4_dp #(
        .MAP_DEPTH   (MAP_DEPTH),
        .SUBST_DEPTH (SUBST_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_mode              (i_mode),
        .i_word_address      (i_word_address),
        .i_word_value        (i_word_value),
        .i_replacement_glyph (i_replacement_glyph),
        .i_code_point        (i_code_point),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_glyph_index       (o_glyph_index),
        .o_status            (o_status)
    );

`ifndef NO_ASSERTIONS
    // any result other than mapped carries glyph zero
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_MAPPED)) |-> (o_glyph_index == '0))
        else $error("unmapped result with nonzero glyph");

    // a lookup request closes the request channel on the next cycle
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_mode == MODE_LOOKUP)) |=> !o_in_ready)
        else $error("request taken during a lookup");

    // a result is only loaded when the result register can take it
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> w_stat.out_free)
        else $error("result overwritten before it was taken");

    // no memory reads are issued while waiting for a request
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!w_cmd.map_rd && !w_cmd.sub_rd && !w_cmd.push))
        else $error("datapath activity while idle");
`endif

endmodule

### tb/tb_cmap4_glyph_lookup.sv
// self-checking testbench for the format-4 character map glyph lookup
module tb_cmap4_glyph_lookup;
    import cmap4_pkg::*;

    localparam int MAP_WORDS = DEF_MAP_DEPTH;
    localparam int SUB_WORDS = DEF_SUBST_DEPTH;
    localparam int SUB_AW    = $clog2(SUB_WORDS);
    localparam int RUN_LIMIT = 25_000_000;

    typedef struct packed {
        logic [WORD_W-1:0] glyph;
        logic [STAT_W-1:0] status;
    } t_glyph_rec;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [WADDR_W-1:0] addr;
        logic [WORD_W-1:0]  val;
        logic [WORD_W-1:0]  rep;
        logic [WORD_W-1:0]  cp;
        logic               typed;
        t_glyph_rec         want;
    } t_step_row;

    // one segment at reset settings: end at 0, start at 2, delta at 3, offset at 4
    localparam int BOOT_LEN = 25;
    localparam t_step_row BOOT_ROWS [BOOT_LEN] = '{
        '{MODE_MAP_WR, 12'h000, 16'h8000, 16'h0000, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}},
        '{MODE_MAP_WR, 12'h002, 16'h0010, 16'hFFFF, 16'hFFFF, 1'b0, '{16'h0000, ST_MAPPED}},
        '{MODE_MAP_WR, 12'h003, 16'h0005, 16'h0000, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}},
        '{MODE_MAP_WR, 12'h004, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, '{16'h0000, ST_MAPPED}},
        // below the segment start
        '{MODE_LOOKUP, 12'h000, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'h0000, ST_UNMAPPED}},
        '{MODE_LOOKUP, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'h0010, 1'b1, '{16'h0015, ST_MAPPED}},
        '{MODE_LOOKUP, 12'h000, 16'h0000, 16'h0000, 16'h8000, 1'b1, '{16'h8005, ST_MAPPED}},
        // past the last segment
        '{MODE_LOOKUP, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, ST_UNMAPPED}},
        '{MODE_MAP_WR, 12'h003, 16'hFFF0, 16'h0000, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}},
        // delta sum wraps to zero
        '{MODE_LOOKUP, 12'h000, 16'h0000, 16'h0000, 16'h0010, 1'b1, '{16'h0000, ST_UNMAPPED}},
        '{MODE_LOOKUP, 12'h000, 16'h0000, 16'h0000, 16'h7FFF, 1'b1, '{16'h7FEF, ST_MAPPED}},
        // glyph array right after the offset word
        '{MODE_MAP_WR, 12'h004, 16'h0002, 16'h0000, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}},
        '{MODE_MAP_WR, 12'h005, 16'h0100, 16'h0000, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}},
        '{MODE_MAP_WR, 12'h006, 16'h0000, 16'h0000, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}},
        '{MODE_LOOKUP, 12'h000, 16'h0000, 16'h0000, 16'h0010, 1'b1, '{16'h00F0, ST_MAPPED}},
        '{MODE_LOOKUP, 12'h000, 16'h0000, 16'h0000, 16'h0011, 1'b1, '{16'h0000, ST_UNMAPPED}},
        '{MODE_MAP_WR, 12'h004, 16'hFFFE, 16'h0000, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}},
        '{MODE_LOOKUP, 12'h000, 16'h0000, 16'h0000, 16'h0010, 1'b1, '{16'h0000, ST_OOB}},
        // array word lands on the top map address, one further is out of store
        '{MODE_MAP_WR, 12'h000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}},
        '{MODE_MAP_WR, 12'h004, 16'h1FF6, 16'h0000, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}},
        '{MODE_MAP_WR, 12'hFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}},
        '{MODE_LOOKUP, 12'h000, 16'h0000, 16'h0000, 16'h0010, 1'b1, '{16'hFFEF, ST_MAPPED}},
        '{MODE_LOOKUP, 12'h000, 16'h0000, 16'h0000, 16'h0011, 1'b1, '{16'h0000, ST_OOB}},
        '{MODE_NOP,    12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '{16'h0000, ST_MAPPED}},
        // substitution index beyond the list is dropped
        '{MODE_SUB_WR, 12'hFFF, 16'hFFEF, 16'h1234, 16'h0000, 1'b0, '{16'h0000, ST_MAPPED}}
    };

    localparam int PHASES = 12;
    localparam int SEG_LO  [PHASES] = '{0, 1, 2,  4,   4,   4,  8, 1023, 16,  2,  2,   4};
    localparam int SEG_HI  [PHASES] = '{0, 1, 8, 16,  16,  16, 16, 1023, 32, 16, 16,  12};
    localparam int SUB_LO  [PHASES] = '{0, 0, 1,  8, 256, 511, 20,  256, 32,  0,  4,  16};
    localparam int SUB_HI  [PHASES] = '{0, 0, 1, 32, 256, 511, 40,  256, 64,  0, 16,  48};
    localparam int VERT    [PHASES] = '{0, 0, 1,  1,   1,   1,  0,    1,  1,  1,  1,   1};
    localparam int QUIET   [PHASES] = '{0, 0, 0,  1,   0,   0,  0,    0,  0,  0,  0,   0};
    localparam int LOOKUPS [PHASES] = '{30, 50, 60, 80, 40, 30, 80, 6, 80, 80, 100, 100};

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CDATA_W-1:0]  cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                o_in_ready;
    logic [MODE_W-1:0]   in_mode = MODE_NOP;
    logic [WADDR_W-1:0]  in_addr = '0;
    logic [WORD_W-1:0]   in_value = '0;
    logic [WORD_W-1:0]   in_repl = '0;
    logic [WORD_W-1:0]   in_code = '0;
    logic                o_out_valid;
    logic                out_ready = 1'b1;
    logic [WORD_W-1:0]   o_glyph_index;
    logic [STAT_W-1:0]   o_status;

    // shadow of the block's map, substitution list and settings
    logic [WORD_W-1:0]   map_mem [MAP_WORDS];
    logic [WORD_W-1:0]   sub_src [SUB_WORDS];
    logic [WORD_W-1:0]   sub_dst [SUB_WORDS];
    logic [SEG_W-1:0]    seg_cnt = 10'd1;
    logic [SUBC_W-1:0]   sub_cnt = '0;
    logic                vert_on = 1'b0;

    t_glyph_rec          glyphs_due [$];
    int unsigned         err_cnt = 0;
    bit                  in_idle_on = 1'b1;
    bit                  out_idle_on = 1'b1;

    cmap4_glyph_lookup #(
        .MAP_DEPTH   (MAP_WORDS),
        .SUBST_DEPTH (SUB_WORDS)
    ) dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_mode              (in_mode),
        .i_word_address      (in_addr),
        .i_word_value        (in_value),
        .i_replacement_glyph (in_repl),
        .i_code_point        (in_code),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (out_ready),
        .o_glyph_index       (o_glyph_index),
        .o_status            (o_status)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT);
        $display("** cmap4_glyph_lookup: FAILED **");
        $finish;
    end

    function automatic logic [WORD_W-1:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic int unsigned word_at(input int unsigned a);
        return map_mem[a[WADDR_W-1:0]];
    endfunction

    function automatic t_glyph_rec map_code_point(input logic [WORD_W-1:0] code,
                                                  input logic use_subst);
        t_glyph_rec  r;
        int unsigned s, i, cp, start, delta, offs, g, a, n, k;
        r.glyph  = '0;
        r.status = ST_UNMAPPED;
        s  = seg_cnt;
        cp = code;
        i  = 0;
        while (i < s) begin
            if (i >= MAP_WORDS) begin
                r.status = ST_OOB;
                return r;
            end
            if (cp <= word_at(i))
                break;
            i++;
        end
        if (i >= s)
            return r;
        // the offset word sits highest of the three segment fields
        a = 3 * s + 1 + i;
        if (a >= MAP_WORDS) begin
            r.status = ST_OOB;
            return r;
        end
        start = word_at(s + 1 + i);
        delta = word_at(2 * s + 1 + i);
        offs  = word_at(a);
        if (cp < start)
            return r;
        if (offs == 0) begin
            g = (cp + delta) & 'hFFFF;
        end else begin
            a = a + (offs >> 1) + (cp - start);
            if (a >= MAP_WORDS) begin
                r.status = ST_OOB;
                return r;
            end
            g = word_at(a);
            if (g != 0)
                g = (g + delta) & 'hFFFF;
        end
        if (g == 0)
            return r;
        if (use_subst) begin
            n = (sub_cnt > SUB_WORDS) ? SUB_WORDS : sub_cnt;
            k = 0;
            while (k < n && sub_src[k[SUB_AW-1:0]] < g)
                k++;
            if (k < n && sub_src[k[SUB_AW-1:0]] == g)
                g = sub_dst[k[SUB_AW-1:0]];
        end
        r.glyph  = g[WORD_W-1:0];
        r.status = ST_MAPPED;
        return r;
    endfunction

    // code point near a random segment, now and then anywhere
    function automatic logic [WORD_W-1:0] pick_code_point();
        int unsigned j, lo, hi;
        if (seg_cnt == 0 || $urandom_range(0, 7) == 0)
            return rnd16();
        j  = $urandom_range(0, seg_cnt - 1);
        lo = word_at(seg_cnt + 1 + j);
        hi = word_at(j);
        lo = (lo > 2) ? lo - 2 : 0;
        hi = (hi < 'hFFFF) ? hi + 1 : hi;
        return 16'($urandom_range(lo, hi));
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [WADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] val, rep, cp, input logic typed,
                            input t_glyph_rec want);
        if (in_idle_on && $urandom_range(0, 99) < 6) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_addr  <= addr;
        in_value <= val;
        in_repl  <= rep;
        in_code  <= cp;
        do @(posedge clk); while (!o_in_ready);
        // request taken at this edge
        case (mode)
            MODE_MAP_WR: map_mem[addr] = val;
            MODE_SUB_WR: begin
                if (addr < SUB_WORDS) begin
                    sub_src[addr[SUB_AW-1:0]] = val;
                    sub_dst[addr[SUB_AW-1:0]] = rep;
                end
            end
            MODE_LOOKUP: glyphs_due.push_back(typed ? want : map_code_point(cp, vert_on));
            default: ;
        endcase
    endtask

    task automatic map_write(input int unsigned a, input int unsigned v);
        send_req(MODE_MAP_WR, 12'(a), 16'(v), rnd16(), rnd16(), 1'b0, '0);
    endtask

    task automatic subst_write(input int unsigned k, input int unsigned src,
                               input int unsigned dst);
        send_req(MODE_SUB_WR, 12'(k), 16'(src), 16'(dst), rnd16(), 1'b0, '0);
    endtask

    task automatic find_glyph(input logic [WORD_W-1:0] cp);
        send_req(MODE_LOOKUP, 12'($urandom), rnd16(), rnd16(), cp, 1'b0, '0);
    endtask

    task automatic settle(input int unsigned tail);
        in_valid <= 1'b0;
        while (glyphs_due.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // write enable stays high across the three register writes
    task automatic load_settings(input int unsigned segs, input int unsigned subs,
                                 input bit vert);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEG_COUNT;
        cfg_data  <= 10'(segs);
        @(posedge clk);
        cfg_index <= CFG_SUB_COUNT;
        cfg_data  <= {1'($urandom), 9'(subs)};
        @(posedge clk);
        cfg_index <= CFG_VERT_EN;
        cfg_data  <= {9'($urandom), vert};
        @(posedge clk);
        cfg_we  <= 1'b0;
        seg_cnt = 10'(segs);
        sub_cnt = 9'(subs);
        vert_on = vert;
    endtask

    // well-formed map: ascending ends, narrow ranges, offsets into a fresh glyph array
    task automatic build_map(input int unsigned s);
        int unsigned step, e, st, offs, g_cnt, i;
        g_cnt = (4 * s + 1 + 64 <= MAP_WORDS) ? 64 : MAP_WORDS - (4 * s + 1);
        step  = (s == 0) ? 65536 : 65536 / s;
        map_write(s, rnd16());
        for (i = 0; i < s; i++) begin
            e = (i + 1) * step - 1 - $urandom_range(0, step / 2);
            if (i == s - 1 && $urandom_range(0, 3) != 0)
                e = 'hFFFF;
            st = e - $urandom_range(0, (e < 48) ? e : 48);
            if ($urandom_range(0, 1) == 0)
                offs = 0;
            else if ($urandom_range(0, 15) == 0)
                offs = rnd16();
            else
                offs = 2 * (s - i + $urandom_range(0, g_cnt - 1));
            map_write(i, e);
            map_write(s + 1 + i, st);
            map_write(2 * s + 1 + i, ($urandom_range(0, 7) == 0) ? 65536 - st : $urandom);
            map_write(3 * s + 1 + i, offs);
        end
        for (i = 0; i < g_cnt; i++)
            map_write(4 * s + 1 + i, ($urandom_range(0, 7) == 0) ? 0 : $urandom);
    endtask

    // sorted substitution list, half of it drawn from glyphs the map produces
    task automatic build_subst(input int unsigned n);
        logic [WORD_W-1:0] src_q [$];
        t_glyph_rec        hit;
        int unsigned       m, k;
        m = (n > SUB_WORDS) ? SUB_WORDS : n;
        for (k = 0; k < m; k++) begin
            hit = map_code_point(pick_code_point(), 1'b0);
            src_q.push_back($urandom_range(0, 1) ? hit.glyph : rnd16());
        end
        src_q.sort();
        for (k = 0; k < m; k++)
            subst_write(k, src_q[k], ($urandom_range(0, 7) == 0) ? 0 : $urandom);
    endtask

    always @(posedge clk)
        out_ready <= !(out_idle_on && $urandom_range(0, 99) < 6);

    always @(posedge clk) begin
        t_glyph_rec due;
        if (rst_n && o_out_valid && out_ready) begin
            if (glyphs_due.size() == 0) begin
                note_error($sformatf("unexpected result: glyph %h status %0d",
                                     o_glyph_index, o_status));
            end else begin
                due = glyphs_due.pop_front();
                if (o_glyph_index !== due.glyph || o_status !== due.status)
                    note_error($sformatf("glyph %h status %0d, expected glyph %h status %0d",
                                         o_glyph_index, o_status, due.glyph, due.status));
            end
        end
    end

    initial begin
        int unsigned p, a, segs, subs, pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < BOOT_LEN; p++)
            send_req(BOOT_ROWS[p].mode, BOOT_ROWS[p].addr, BOOT_ROWS[p].val,
                     BOOT_ROWS[p].rep, BOOT_ROWS[p].cp, BOOT_ROWS[p].typed,
                     BOOT_ROWS[p].want);

        // fill both stores so that no lookup ever touches an unwritten word
        for (a = 0; a < MAP_WORDS; a++)
            map_write(a, $urandom);
        for (a = 0; a < SUB_WORDS; a++)
            subst_write(a, $urandom, $urandom);

        for (p = 0; p < PHASES; p++) begin
            settle(8);
            in_idle_on  = (QUIET[p] == 0);
            out_idle_on = (QUIET[p] == 0);
            segs = $urandom_range(SEG_LO[p], SEG_HI[p]);
            subs = $urandom_range(SUB_LO[p], SUB_HI[p]);
            load_settings(segs, subs, VERT[p] != 0);
            build_map(segs);
            build_subst(subs);
            repeat (LOOKUPS[p]) begin
                pick = $urandom_range(0, 99);
                if (pick < 88)
                    find_glyph(pick_code_point());
                else if (pick < 92)
                    send_req(MODE_NOP, 12'($urandom), rnd16(), rnd16(), rnd16(), 1'b0, '0);
                else if (pick < 96)
                    subst_write($urandom_range(0, 4095), $urandom, $urandom);
                else
                    map_write($urandom_range(0, 4095), $urandom);
            end
        end

        settle(2 * int'(seg_cnt) + 2 * SUB_WORDS + 32);
        if (err_cnt == 0)
            $display("** cmap4_glyph_lookup: PASSED **");
        else
            $display("** cmap4_glyph_lookup: FAILED **");
        $finish;
    end

endmodule

### filelist.f
sv/cmap4_pkg.sv
sv/cmap4_ctrl.sv
sv/cmap4_dp.sv
sv/cmap4_glyph_lookup.sv
tb/tb_cmap4_glyph_lookup.sv
